// ----- src/hsc_pkg.sv -----
`default_nettype none

package hsc_pkg;

    // Fixed field widths
    localparam int CODE_W = 64;
    localparam int LEN_W  = 7;
    localparam int SYN_W  = 7;

    // Code length limits
    localparam int MIN_CODE_BITS     = 3;
    localparam int MAX_CODE_BITS_DEF = 64;
    localparam int LEN_RESET         = 64;

    // Action codes
    localparam logic [1:0] ACT_ENCODE  = 2'd0;
    localparam logic [1:0] ACT_CHECK   = 2'd1;
    localparam logic [1:0] ACT_EXTRACT = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_CORR    = 2'd1;
    localparam logic [1:0] ST_UNCORR  = 2'd2;

    typedef struct packed {
        logic [1:0]        action;
        logic [CODE_W-1:0] word;
    } t_hsc_in;

    typedef struct packed {
        logic [CODE_W-1:0] result_word;
        logic [1:0]        status;
        logic [SYN_W-1:0]  error_position;
    } t_hsc_out;

    // True when position k is a parity position
    function automatic logic is_pow2(input int k);
        return (k & (k - 1)) == 0;
    endfunction

    // Data bit index carried at non-parity position k (1-based)
    function automatic logic [5:0] data_idx(input int k);
        int lg;
        lg = 0;
        for (int b = 1; b < 8; b++) begin
            if ((k >> b) != 0) begin
                lg = b;
            end
        end
        if (is_pow2(k)) begin
            return 6'd0;
        end
        return 6'(k - 2 - lg);
    endfunction

    // Word bits whose 1-based position has syndrome bit i set
    function automatic logic [CODE_W-1:0] syn_mask(input int i);
        logic [CODE_W-1:0] m;
        m = '0;
        for (int k = 1; k <= CODE_W; k++) begin
            m[k-1] = ((k >> i) & 1) != 0;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- src/hamming_sec_codec.sv -----
// Hamming single-error-correcting codec, one item per cycle.
// An accepted item loads the input register; the result register loads after it
// and drives o_result, with o_valid registered alongside it.
// Throughput: one item every cycle; busy stays low and the receiver cannot stall.
// Timing is set by the scatter/gather muxes and the 64-bit syndrome XOR trees.
// Reset clears the valid flags and sets the code length to 64 (capped at MAX_CODE_BITS).
`default_nettype none

module hamming_sec_codec #(
    parameter int MAX_CODE_BITS = hsc_pkg::MAX_CODE_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire hsc_pkg::t_hsc_in         i_item,
    input  wire logic                     i_cfg_we,
    input  wire logic [hsc_pkg::LEN_W-1:0] i_cfg_data,
    output logic                          o_valid,
    output hsc_pkg::t_hsc_out             o_result
);
    import hsc_pkg::*;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_CODE_BITS);
    localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(MIN_CODE_BITS);
    localparam logic [LEN_W-1:0] LEN_RST =
        (LEN_RESET > MAX_CODE_BITS) ? LEN_W'(MAX_CODE_BITS) : LEN_W'(LEN_RESET);

    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  n_len;
    logic              r_in_valid;
    t_hsc_in           r_in;
    logic              r_out_valid;
    t_hsc_out          r_out;
    t_hsc_out          n_out;

    logic [CODE_W-1:0] len_mask;
    logic [CODE_W-1:0] scattered;
    logic [CODE_W-1:0] gathered;
    logic [CODE_W-1:0] masked;
    logic [CODE_W-1:0] parity_bits;
    logic [SYN_W-1:0]  enc_syn;
    logic [SYN_W-1:0]  chk_syn;
    logic [LEN_W-1:0]  flip_pos;

    assign busy = 1'b0;

    // Clamp the written code length into the supported range
    always_comb begin
        n_len = i_cfg_data;
        if (i_cfg_data < LEN_MIN) begin
            n_len = LEN_MIN;
        end else if (i_cfg_data > LEN_MAX) begin
            n_len = LEN_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_RST;
        end else if (i_cfg_we) begin
            r_len <= n_len;
        end
    end

    // Capture the accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_in <= i_item;
        end
    end

    // Position masks, scatter of data bits and gather of data bits
    always_comb begin
        len_mask  = '0;
        scattered = '0;
        gathered  = '0;
        for (int k = 1; k <= CODE_W; k++) begin
            len_mask[k-1] = (LEN_W'(k) <= r_len);
            if (!is_pow2(k)) begin
                scattered[k-1] = (LEN_W'(k) <= r_len) & r_in.word[data_idx(k)];
                gathered[data_idx(k)] = (LEN_W'(k) <= r_len) & r_in.word[k-1];
            end
        end
    end

    assign masked = r_in.word & len_mask;

    // Syndromes as XOR trees over fixed position masks
    always_comb begin
        enc_syn     = '0;
        chk_syn     = '0;
        parity_bits = '0;
        for (int i = 0; i < SYN_W; i++) begin
            enc_syn[i] = ^(scattered & syn_mask(i));
            chk_syn[i] = ^(masked & syn_mask(i));
        end
        for (int i = 0; i < SYN_W; i++) begin
            if ((1 << i) <= CODE_W) begin
                parity_bits[(1 << i) - 1] = enc_syn[i];
            end
        end
    end

    assign flip_pos = chk_syn - LEN_W'(1);

    // Select the result for the action
    always_comb begin
        n_out = '0;
        case (r_in.action)
            ACT_ENCODE: begin
                n_out.result_word = scattered | parity_bits;
            end
            ACT_CHECK: begin
                n_out.result_word    = masked;
                n_out.error_position = chk_syn;
                if (chk_syn == '0) begin
                    n_out.status = ST_OK;
                end else if (chk_syn <= r_len) begin
                    n_out.result_word = masked ^ (CODE_W'(1) << flip_pos[5:0]);
                    n_out.status      = ST_CORR;
                end else begin
                    n_out.status = ST_UNCORR;
                end
            end
            ACT_EXTRACT: begin
                n_out.result_word = gathered;
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    // Register the result and its strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire
